>>> rtl/stt_pkg.sv
// Shared types, codes and character classes for the schema text tokenizer.
`timescale 1ns / 1ps

package stt_pkg;

    localparam logic [2:0] KIND_IDENT  = 3'd0;
    localparam logic [2:0] KIND_STRING = 3'd1;
    localparam logic [2:0] KIND_NUMBER = 3'd2;
    localparam logic [2:0] KIND_SYMBOL = 3'd3;
    localparam logic [2:0] KIND_END    = 3'd4;
    localparam logic [2:0] KIND_ERROR  = 3'd5;

    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_COMMENT    = 2'd1;
    localparam logic [1:0] ERR_STRING     = 2'd2;
    localparam logic [1:0] ERR_UNEXPECTED = 2'd3;

    localparam int MaxResults = 4;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  value;
        logic        has_char;
        logic        first;
        logic        last;
        logic [15:0] line;
        logic [1:0]  err;
    } result_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_symbol(input logic [7:0] c);
        return c == "{" || c == "}" || c == "[" || c == "]" || c == "(" || c == ")" ||
               c == "=" || c == ";" || c == "," || c == "<" || c == ">" || c == ".";
    endfunction

    function automatic result_t make_result(input logic [2:0] kind, input logic [7:0] value,
                                            input logic has_char, input logic first,
                                            input logic last, input logic [15:0] line,
                                            input logic [1:0] err);
        result_t r;
        r.kind     = kind;
        r.value    = value;
        r.has_char = has_char;
        r.first    = first;
        r.last     = last;
        r.line     = line;
        r.err      = err;
        return r;
    endfunction

endpackage

>>> rtl/schema_text_tokenizer.sv
// Schema text tokenizer: byte stream in, tagged token characters out.
//
// The s_ channel carries one source byte per transaction: tdata is the byte,
// tuser says the byte is present, tlast marks the end of the source text.
// Each input transaction causes zero to three result transactions on the m_
// channel; tlast marks the last result caused by one input transaction.
// The byte is decoded in the cycle it is accepted and its results appear on
// the m_ channel on the next cycle. A new byte is accepted in every cycle in
// which the result buffer is empty or its final result is being taken, so a
// stream that makes at most one result per byte runs at one byte per clock;
// a byte that makes several results holds off the next byte until its
// buffered results have all been taken, one result per transaction.
// While the receiver stalls, the result buffer holds and s_tready stays low
// once the buffered results are not about to drain.
// A synchronous active-low reset empties the result buffer and returns the
// scanner to the start of a source at line one. Source end also returns the
// scanner to that state after its end or error result.
`timescale 1ns / 1ps

module schema_text_tokenizer #(
    parameter int LINE_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] src_byte
    input  logic        s_tuser,   // [0] byte_present
    input  logic        s_tlast,   // source_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] value_byte, [8] token_first, [9] token_last,
                                   // [25:10] line_number, [27:26] error_code, rest zero
    output logic [3:0]  m_tuser,   // [2:0] token_kind, [3] has_char
    output logic        m_tlast    // run_last
);

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_NUMBER, M_SLASH, M_MINUS, M_LCOMM,
        M_BCOMM, M_BSTAR, M_STR, M_ESC, M_ERROR
    } mode_t;

    localparam logic [LINE_BITS-1:0] LineTop = '1;
    localparam logic [LINE_BITS-1:0] LineOne = LINE_BITS'(1);

    mode_t                mode_reg, mode_next;
    logic [LINE_BITS-1:0] line_reg, line_next;
    logic [LINE_BITS-1:0] start_reg, start_next;
    logic [7:0]           quote_reg, quote_next;
    logic [7:0]           pend_reg, pend_next;
    logic [7:0]           held_char_reg, held_char_next;
    logic                 held_valid_reg, held_valid_next;
    logic                 held_first_reg, held_first_next;
    logic                 exp_reg, exp_next;

    stt_pkg::result_t res_reg [stt_pkg::MaxResults];
    stt_pkg::result_t res_next [stt_pkg::MaxResults];
    logic [2:0]       cnt_reg, cnt_next;
    logic [1:0]       idx_reg;

    logic s_fire, m_fire;

    function automatic logic [15:0] sat_line(input logic [LINE_BITS-1:0] l);
        logic [31:0] e;
        e = 32'(l);
        return (e > 32'hFFFF) ? 16'hFFFF : e[15:0];
    endfunction

    function automatic logic [2:0] open_kind(input mode_t m);
        if (m == M_STR || m == M_ESC) return stt_pkg::KIND_STRING;
        if (m == M_NUMBER || m == M_MINUS) return stt_pkg::KIND_NUMBER;
        return stt_pkg::KIND_IDENT;
    endfunction

    always_comb begin
        logic [7:0] c;
        logic [7:0] push_c;
        logic       push_en;
        logic       do_idle;
        logic       finish;
        logic [2:0] n;

        c = s_tdata;
        push_c = 8'd0;
        push_en = 1'b0;
        do_idle = 1'b0;
        finish = 1'b0;
        n = 3'd0;
        for (int i = 0; i < stt_pkg::MaxResults; i++) begin
            res_next[i] = '0;
        end
        mode_next = mode_reg;
        line_next = line_reg;
        start_next = start_reg;
        quote_next = quote_reg;
        pend_next = pend_reg;
        held_char_next = held_char_reg;
        held_valid_next = held_valid_reg;
        held_first_next = held_first_reg;
        exp_next = exp_reg;

        if (s_tuser) begin
            unique case (mode_reg)
                M_IDENT: begin
                    if (stt_pkg::is_alpha(c) || stt_pkg::is_digit(c) ||
                        c == "_" || c == ".") begin
                        push_en = 1'b1;
                        push_c = c;
                    end else begin
                        finish = 1'b1;
                        do_idle = 1'b1;
                    end
                end
                M_NUMBER: begin
                    if (stt_pkg::is_alpha(c) || stt_pkg::is_digit(c) || c == "." ||
                        ((c == "+" || c == "-") && exp_reg)) begin
                        push_en = 1'b1;
                        push_c = c;
                        exp_next = (c == "e" || c == "E");
                    end else begin
                        finish = 1'b1;
                        do_idle = 1'b1;
                    end
                end
                M_SLASH: begin
                    if (c == "/") begin
                        mode_next = M_LCOMM;
                    end else if (c == "*") begin
                        mode_next = M_BCOMM;
                    end else begin
                        res_next[n[1:0]] = stt_pkg::make_result(stt_pkg::KIND_ERROR, 8'd0,
                            1'b0, 1'b1, 1'b1, sat_line(start_reg), stt_pkg::ERR_UNEXPECTED);
                        n = n + 3'd1;
                        mode_next = M_ERROR;
                    end
                end
                M_MINUS: begin
                    if (stt_pkg::is_digit(c)) begin
                        // The held minus sign goes out as the first number byte.
                        mode_next = M_NUMBER;
                        res_next[n[1:0]] = stt_pkg::make_result(stt_pkg::KIND_NUMBER,
                            pend_reg, 1'b1, 1'b1, 1'b0, sat_line(start_reg),
                            stt_pkg::ERR_NONE);
                        n = n + 3'd1;
                        held_first_next = 1'b0;
                        held_valid_next = 1'b1;
                        held_char_next = c;
                        exp_next = 1'b0;
                    end else begin
                        res_next[n[1:0]] = stt_pkg::make_result(stt_pkg::KIND_ERROR, 8'd0,
                            1'b0, 1'b1, 1'b1, sat_line(start_reg), stt_pkg::ERR_UNEXPECTED);
                        n = n + 3'd1;
                        mode_next = M_ERROR;
                    end
                end
                M_LCOMM: begin
                    if (c == 8'h0A) begin
                        if (line_reg != LineTop) line_next = line_reg + LineOne;
                        mode_next = M_IDLE;
                    end
                end
                M_BCOMM: begin
                    if (c == "*") begin
                        mode_next = M_BSTAR;
                    end else if (c == 8'h0A) begin
                        if (line_reg != LineTop) line_next = line_reg + LineOne;
                    end
                end
                M_BSTAR: begin
                    if (c == "/") begin
                        mode_next = M_IDLE;
                    end else if (c != "*") begin
                        if (c == 8'h0A && line_reg != LineTop) line_next = line_reg + LineOne;
                        mode_next = M_BCOMM;
                    end
                end
                M_STR: begin
                    if (c == quote_reg) begin
                        finish = 1'b1;
                        mode_next = M_IDLE;
                    end else if (c == "\\") begin
                        mode_next = M_ESC;
                    end else begin
                        if (c == 8'h0A && line_reg != LineTop) line_next = line_reg + LineOne;
                        push_en = 1'b1;
                        push_c = c;
                    end
                end
                M_ESC: begin
                    push_en = 1'b1;
                    push_c = (c == "n") ? 8'h0A : (c == "t") ? 8'h09 : (c == "r") ? 8'h0D : c;
                    mode_next = M_STR;
                end
                M_ERROR: begin
                end
                default: begin
                    do_idle = 1'b1;
                end
            endcase

            if (finish) begin
                if (held_valid_reg) begin
                    res_next[n[1:0]] = stt_pkg::make_result(open_kind(mode_reg),
                        held_char_reg, 1'b1, held_first_reg, 1'b1, sat_line(start_reg),
                        stt_pkg::ERR_NONE);
                end else begin
                    res_next[n[1:0]] = stt_pkg::make_result(open_kind(mode_reg), 8'd0, 1'b0,
                        1'b1, 1'b1, sat_line(start_reg), stt_pkg::ERR_NONE);
                end
                n = n + 3'd1;
                held_valid_next = 1'b0;
                held_first_next = 1'b0;
                held_char_next = 8'd0;
                mode_next = M_IDLE;
            end

            if (do_idle) begin
                held_valid_next = 1'b0;
                held_first_next = 1'b0;
                start_next = line_reg;
                mode_next = M_IDLE;
                if (c == 8'h0A) begin
                    if (line_reg != LineTop) line_next = line_reg + LineOne;
                end else if (stt_pkg::is_space(c)) begin
                    mode_next = M_IDLE;
                end else if (c == "/" || c == "-") begin
                    pend_next = c;
                    mode_next = (c == "/") ? M_SLASH : M_MINUS;
                end else if (c == "\"" || c == "'") begin
                    quote_next = c;
                    mode_next = M_STR;
                end else if (stt_pkg::is_alpha(c) || c == "_") begin
                    mode_next = M_IDENT;
                    push_en = 1'b1;
                    push_c = c;
                end else if (stt_pkg::is_digit(c)) begin
                    mode_next = M_NUMBER;
                    exp_next = 1'b0;
                    push_en = 1'b1;
                    push_c = c;
                end else if (stt_pkg::is_symbol(c)) begin
                    res_next[n[1:0]] = stt_pkg::make_result(stt_pkg::KIND_SYMBOL, c, 1'b1,
                        1'b1, 1'b1, sat_line(line_reg), stt_pkg::ERR_NONE);
                    n = n + 3'd1;
                end else begin
                    res_next[n[1:0]] = stt_pkg::make_result(stt_pkg::KIND_ERROR, 8'd0, 1'b0,
                        1'b1, 1'b1, sat_line(line_reg), stt_pkg::ERR_UNEXPECTED);
                    n = n + 3'd1;
                    mode_next = M_ERROR;
                end
            end

            // A pushed byte releases the previously held byte of the same token.
            if (push_en) begin
                if (held_valid_next) begin
                    res_next[n[1:0]] = stt_pkg::make_result(open_kind(mode_next),
                        held_char_next, 1'b1, held_first_next, 1'b0, sat_line(start_next),
                        stt_pkg::ERR_NONE);
                    n = n + 3'd1;
                    held_first_next = 1'b0;
                end else begin
                    held_first_next = 1'b1;
                end
                held_char_next = push_c;
                held_valid_next = 1'b1;
            end
        end

        if (s_tlast) begin
            unique case (mode_next)
                M_IDENT, M_NUMBER: begin
                    res_next[n[1:0]] = stt_pkg::make_result(open_kind(mode_next),
                        held_char_next, held_valid_next,
                        held_valid_next ? held_first_next : 1'b1, 1'b1,
                        sat_line(start_next), stt_pkg::ERR_NONE);
                    if (!held_valid_next) res_next[n[1:0]].value = 8'd0;
                    n = n + 3'd1;
                    res_next[n[1:0]] = stt_pkg::make_result(stt_pkg::KIND_END, 8'd0, 1'b0,
                        1'b1, 1'b1, sat_line(line_next), stt_pkg::ERR_NONE);
                    n = n + 3'd1;
                end
                M_SLASH, M_MINUS: begin
                    res_next[n[1:0]] = stt_pkg::make_result(stt_pkg::KIND_ERROR, 8'd0, 1'b0,
                        1'b1, 1'b1, sat_line(start_next), stt_pkg::ERR_UNEXPECTED);
                    n = n + 3'd1;
                end
                M_BCOMM, M_BSTAR: begin
                    res_next[n[1:0]] = stt_pkg::make_result(stt_pkg::KIND_ERROR, 8'd0, 1'b0,
                        1'b1, 1'b1, sat_line(line_next), stt_pkg::ERR_COMMENT);
                    n = n + 3'd1;
                end
                M_STR, M_ESC: begin
                    res_next[n[1:0]] = stt_pkg::make_result(stt_pkg::KIND_ERROR, 8'd0, 1'b0,
                        1'b1, 1'b1, sat_line(start_next), stt_pkg::ERR_STRING);
                    n = n + 3'd1;
                end
                M_ERROR: begin
                end
                default: begin
                    res_next[n[1:0]] = stt_pkg::make_result(stt_pkg::KIND_END, 8'd0, 1'b0,
                        1'b1, 1'b1, sat_line(line_next), stt_pkg::ERR_NONE);
                    n = n + 3'd1;
                end
            endcase
            mode_next = M_IDLE;
            line_next = LineOne;
            start_next = LineOne;
            quote_next = 8'd0;
            pend_next = 8'd0;
            held_char_next = 8'd0;
            held_valid_next = 1'b0;
            held_first_next = 1'b0;
            exp_next = 1'b0;
        end
        cnt_next = n;
    end

    assign m_tvalid = (cnt_reg != 3'd0);
    assign m_tlast  = ({1'b0, idx_reg} == cnt_reg - 3'd1);
    assign s_tready = !m_tvalid || (m_tlast && m_tready);
    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = m_tvalid && m_tready;

    assign m_tdata = {4'd0, res_reg[idx_reg].err, res_reg[idx_reg].line,
                      res_reg[idx_reg].last, res_reg[idx_reg].first, res_reg[idx_reg].value};
    assign m_tuser = {res_reg[idx_reg].has_char, res_reg[idx_reg].kind};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_IDLE;
            line_reg <= LineOne;
            start_reg <= LineOne;
            quote_reg <= 8'd0;
            pend_reg <= 8'd0;
            held_char_reg <= 8'd0;
            held_valid_reg <= 1'b0;
            held_first_reg <= 1'b0;
            exp_reg <= 1'b0;
            cnt_reg <= 3'd0;
            idx_reg <= 2'd0;
        end else begin
            if (s_fire) begin
                mode_reg <= mode_next;
                line_reg <= line_next;
                start_reg <= start_next;
                quote_reg <= quote_next;
                pend_reg <= pend_next;
                held_char_reg <= held_char_next;
                held_valid_reg <= held_valid_next;
                held_first_reg <= held_first_next;
                exp_reg <= exp_next;
                cnt_reg <= cnt_next;
                idx_reg <= 2'd0;
            end else if (m_fire) begin
                if (m_tlast) begin
                    cnt_reg <= 3'd0;
                end else begin
                    idx_reg <= idx_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            for (int i = 0; i < stt_pkg::MaxResults; i++) begin
                res_reg[i] <= res_next[i];
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 3'd4 && (!m_tvalid || {1'b0, idx_reg} < cnt_reg))
        else $error("result buffer index out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(idx_reg))
        else $error("buffered result moved while stalled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2:0] == stt_pkg::KIND_ERROR |->
            m_tdata[27:26] != stt_pkg::ERR_NONE && !m_tuser[3] && m_tlast)
        else $error("error result malformed");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input accepted before results drained");

endmodule
